// File: src/mcbd_pkg.sv
// ----------------------------------------------------------------------------
// mcbd_pkg: shared types and constants for the mip chain box downsampler
// Pixel, partial sum, result and request types, stage control and defaults.
// ----------------------------------------------------------------------------
package mcbd_pkg;

  localparam int MAX_LOG2_SIZE_DEF = 8;

  localparam int CFG_W   = 4;
  localparam int CH_W    = 8;
  localparam int SUM_W   = 9;
  localparam int XY_W    = 7;
  localparam int LEVEL_W = 4;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  typedef struct packed {
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
    logic [CH_W-1:0] alpha_in;
  } in_req_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] mip_level;
    logic [XY_W-1:0]    out_x;
    logic [XY_W-1:0]    out_y;
    logic [CH_W-1:0]    red_out;
    logic [CH_W-1:0]    green_out;
    logic [CH_W-1:0]    blue_out;
    logic [CH_W-1:0]    alpha_out;
    logic               last_of_run;
  } out_res_t;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
    logic [CH_W-1:0] a;
  } pix_t;

  typedef struct packed {
    logic [SUM_W-1:0] r;
    logic [SUM_W-1:0] g;
    logic [SUM_W-1:0] b;
    logic [SUM_W-1:0] a;
  } psum_t;

  typedef struct packed {
    logic [XY_W-1:0] x;
    logic [XY_W-1:0] y;
    pix_t            px;
  } res_t;

  typedef struct packed {
    logic valid;
    logic go;
  } stage_ctl_t;

endpackage

// File: src/mcbd_ram.sv
// ----------------------------------------------------------------------------
// mcbd_ram: generic simple dual port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mcbd_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 2,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: src/mcbd_cell.sv
// ----------------------------------------------------------------------------
// mcbd_cell: one source level of the mip chain
// Counts pixel positions of its level, pairs columns, keeps the even row
// pair sums in a row RAM and hands the 2x2 mean to the next cell.
// ----------------------------------------------------------------------------
module mcbd_cell
  import mcbd_pkg::*;
#(
  parameter int MAX_LOG2_SIZE = MAX_LOG2_SIZE_DEF,
  parameter int LEVEL         = 0,
  parameter int CNT_W         = $clog2(MAX_LOG2_SIZE + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             restart,
  input  logic [CFG_W-1:0] log2_size,
  input  stage_ctl_t       up_ctl,
  input  pix_t             up_px,
  input  logic [CNT_W-1:0] up_cnt,
  input  res_t             up_res [MAX_LOG2_SIZE],
  output stage_ctl_t       dn_ctl,
  output pix_t             dn_px,
  output logic [CNT_W-1:0] dn_cnt,
  output res_t             dn_res [MAX_LOG2_SIZE]
);

  localparam int SPAN   = MAX_LOG2_SIZE - LEVEL;
  localparam int POS_W  = 2 * SPAN;
  localparam int ADDR_W = (SPAN > 1) ? SPAN - 1 : 1;
  localparam int DEPTH  = 2 ** (SPAN - 1);

  logic [POS_W-1:0] pos_r, pos_nxt, pos_inc, mask, col_c, row_c, col_n;
  logic [CFG_W-1:0] shift;
  logic             active, take, odd_x, odd_y, wrap, wr_en, emit;
  pix_t             pair_r;
  psum_t            sum_c, row_rd;
  pix_t             mean_c;
  res_t             res_new;
  res_t             res_nxt [MAX_LOG2_SIZE];

  stage_ctl_t       dn_ctl_r;
  pix_t             dn_px_r;
  logic [CNT_W-1:0] dn_cnt_r;
  res_t             dn_res_r [MAX_LOG2_SIZE];

  always_comb begin
    active  = CFG_W'(LEVEL) < log2_size;
    shift   = log2_size - CFG_W'(LEVEL);
    mask    = (POS_W'(1) << shift) - POS_W'(1);
    col_c   = pos_r & mask;
    row_c   = (pos_r >> shift) & mask;
    odd_x   = col_c[0];
    odd_y   = row_c[0];
    wrap    = (col_c == mask) && (row_c == mask);
    pos_inc = wrap ? '0 : pos_r + POS_W'(1);
    take    = adv && up_ctl.valid && up_ctl.go && active;
    pos_nxt = restart ? '0 : (take ? pos_inc : pos_r);
    col_n   = pos_nxt & mask;

    sum_c.r = {1'b0, pair_r.r} + {1'b0, up_px.r};
    sum_c.g = {1'b0, pair_r.g} + {1'b0, up_px.g};
    sum_c.b = {1'b0, pair_r.b} + {1'b0, up_px.b};
    sum_c.a = {1'b0, pair_r.a} + {1'b0, up_px.a};

    wr_en = take && odd_x && !odd_y;
    emit  = take && odd_x && odd_y;

    mean_c.r = CH_W'(({1'b0, sum_c.r} + {1'b0, row_rd.r}) >> 2);
    mean_c.g = CH_W'(({1'b0, sum_c.g} + {1'b0, row_rd.g}) >> 2);
    mean_c.b = CH_W'(({1'b0, sum_c.b} + {1'b0, row_rd.b}) >> 2);
    mean_c.a = CH_W'(({1'b0, sum_c.a} + {1'b0, row_rd.a}) >> 2);

    res_new.x  = XY_W'(col_c >> 1);
    res_new.y  = XY_W'(row_c >> 1);
    res_new.px = mean_c;

    res_nxt = up_res;
    if (emit) begin
      res_nxt[LEVEL] = res_new;
    end
  end

  // even row pair sums, prefetched at the next position's column
  mcbd_ram #(
    .WIDTH ($bits(psum_t)),
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_row_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(col_c[ADDR_W:1]),
    .wr_data(sum_c),
    .rd_addr(col_n[ADDR_W:1]),
    .rd_data(row_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !odd_x) begin
      pair_r <= up_px;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dn_ctl_r <= '0;
    end else if (adv) begin
      dn_ctl_r.valid <= up_ctl.valid;
      dn_ctl_r.go    <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dn_px_r  <= mean_c;
      dn_cnt_r <= emit ? CNT_W'(LEVEL + 1) : up_cnt;
      dn_res_r <= res_nxt;
    end
  end

  assign dn_ctl = dn_ctl_r;
  assign dn_px  = dn_px_r;
  assign dn_cnt = dn_cnt_r;
  assign dn_res = dn_res_r;

endmodule

// File: src/mcbd_serial.sv
// ----------------------------------------------------------------------------
// mcbd_serial: result serialiser
// Holds one request's results, sent one a cycle in level order unless stalled.
// ----------------------------------------------------------------------------
module mcbd_serial
  import mcbd_pkg::*;
#(
  parameter int MAX_LOG2_SIZE = MAX_LOG2_SIZE_DEF,
  parameter int CNT_W         = $clog2(MAX_LOG2_SIZE + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             tail_valid,
  input  logic [CNT_W-1:0] tail_cnt,
  input  res_t             tail_res [MAX_LOG2_SIZE],
  input  logic             out_stall,
  output logic             out_valid,
  output out_res_t         out_res,
  output logic             adv
);

  localparam int IDX_W = (MAX_LOG2_SIZE > 1) ? $clog2(MAX_LOG2_SIZE) : 1;

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt, cnt_r;
  res_t             res_r [MAX_LOG2_SIZE];
  res_t             cur;
  logic             fire, last, free, load;

  always_comb begin
    cur      = res_r[idx_r[IDX_W-1:0]];
    fire     = busy_r && !out_stall;
    last     = (idx_r + CNT_W'(1)) == cnt_r;
    free     = !busy_r || (fire && last);
    load     = tail_valid && (tail_cnt != '0) && free;
    adv      = !tail_valid || (tail_cnt == '0) || free;
    busy_nxt = load ? 1'b1 : ((fire && last) ? 1'b0 : busy_r);
    idx_nxt  = load ? '0 : (fire ? idx_r + CNT_W'(1) : idx_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= tail_res;
      cnt_r <= tail_cnt;
    end
  end

  always_comb begin
    out_valid           = busy_r;
    out_res.mip_level   = LEVEL_W'(idx_r) + LEVEL_W'(1);
    out_res.out_x       = cur.x;
    out_res.out_y       = cur.y;
    out_res.red_out     = cur.px.r;
    out_res.green_out   = cur.px.g;
    out_res.blue_out    = cur.px.b;
    out_res.alpha_out   = cur.px.a;
    out_res.last_of_run = last;
  end

endmodule

// File: src/mip_chain_box_downsampler_core.sv
// ----------------------------------------------------------------------------
// mip_chain_box_downsampler_core: streaming 2x2 box filter mip chain
// Throughput: one request a cycle while in_stall is low; a request with results
//   can hold the input back while the serialiser still sends them.
// Path: a request passes one registered cell per source level, then the
//   serialiser register, before its first result appears.
// Reset: synchronous, active low; log2 size returns to 8, all level counters
//   to zero. No clearing pass.
// ----------------------------------------------------------------------------
module mip_chain_box_downsampler_core
  import mcbd_pkg::*;
#(
  parameter int MAX_LOG2_SIZE = MAX_LOG2_SIZE_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_req_t          in_req,
  output logic             out_valid,
  input  logic             out_stall,
  output out_res_t         out_res,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(MAX_LOG2_SIZE + 1);

  logic [CFG_W-1:0] log2_r, log2_eff;
  logic             cfg_fire, adv;

  stage_ctl_t       st_ctl [MAX_LOG2_SIZE+1];
  pix_t             st_px  [MAX_LOG2_SIZE+1];
  logic [CNT_W-1:0] st_cnt [MAX_LOG2_SIZE+1];
  res_t             st_res [MAX_LOG2_SIZE+1][MAX_LOG2_SIZE];

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign log2_eff  = (log2_r > CFG_W'(MAX_LOG2_SIZE)) ? CFG_W'(MAX_LOG2_SIZE) : log2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log2_r <= CFG_RESET;
    end else if (cfg_fire) begin
      log2_r <= cfg_data;
    end
  end

  assign st_ctl[0].valid = in_valid;
  assign st_ctl[0].go    = 1'b1;
  assign st_px[0].r      = in_req.red_in;
  assign st_px[0].g      = in_req.green_in;
  assign st_px[0].b      = in_req.blue_in;
  assign st_px[0].a      = in_req.alpha_in;
  assign st_cnt[0]       = '0;

  for (genvar k = 0; k < MAX_LOG2_SIZE; k++) begin : g_res_zero
    assign st_res[0][k] = '0;
  end

  for (genvar j = 0; j < MAX_LOG2_SIZE; j++) begin : g_cell
    mcbd_cell #(
      .MAX_LOG2_SIZE(MAX_LOG2_SIZE),
      .LEVEL        (j),
      .CNT_W        (CNT_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .restart  (cfg_fire),
      .log2_size(log2_eff),
      .up_ctl   (st_ctl[j]),
      .up_px    (st_px[j]),
      .up_cnt   (st_cnt[j]),
      .up_res   (st_res[j]),
      .dn_ctl   (st_ctl[j+1]),
      .dn_px    (st_px[j+1]),
      .dn_cnt   (st_cnt[j+1]),
      .dn_res   (st_res[j+1])
    );
  end

  mcbd_serial #(
    .MAX_LOG2_SIZE(MAX_LOG2_SIZE),
    .CNT_W        (CNT_W)
  ) u_serial (
    .clk       (clk),
    .rst_n     (rst_n),
    .tail_valid(st_ctl[MAX_LOG2_SIZE].valid),
    .tail_cnt  (st_cnt[MAX_LOG2_SIZE]),
    .tail_res  (st_res[MAX_LOG2_SIZE]),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res),
    .adv       (adv)
  );

  assign in_stall = !adv;

  // an empty chain tail never holds the input back
  a_empty_tail_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !st_ctl[MAX_LOG2_SIZE].valid |-> !in_stall)
    else $error("input stalled with empty chain tail");

  // input held back only while results are pending
  a_stall_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no pending result");

  // levels of one run rise by one
  a_level_ascends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_res.last_of_run |=>
      out_valid && (out_res.mip_level == LEVEL_W'($past(out_res.mip_level) + 1'b1)))
    else $error("run broken before its last result");

endmodule
